[design/tidtec_pkg.sv]
// Shared types, constants and tables of the ionospheric disturbance screen evaluator.
package tidtec_pkg;

    localparam int MAX_COMPONENTS = 16;
    localparam int PHASE_BITS     = 24;
    localparam int CIDX_W         = $clog2(MAX_COMPONENTS);
    localparam int CNT_W          = $clog2(MAX_COMPONENTS + 1);

    localparam int EARTH_RADIUS_KM  = 6365;
    localparam int SECONDS_PER_HOUR = 3600;

    localparam int ENTRY_W = 160;
    localparam int IN_W    = 232;
    localparam int OUT_W   = 48;
    localparam int CFG_W   = 40;

    localparam logic [33:0] PI_Q32  = 34'd13493037705;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

    localparam logic [5:0] THETA_DIV = 6'd45;
    // Reciprocals of 45: exact quotients for 32-bit dividends (shift 38) and 13-bit ones (shift 19).
    localparam logic [32:0] THETA_RCP      = 33'd6108397933;
    localparam logic [13:0] THETA_FRAC_RCP = 14'd11651;

    localparam logic [1:0] CFG_TEC0   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TIME   = 2'd2;
    localparam logic [1:0] CFG_COUNT  = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [6:0] COS_DIV [5] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [6:0] SIN_DIV [5] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};

    localparam logic [30:0] COS_RCP [5] = '{
        31'(64'd2147483648 / 64'd90), 31'(64'd2147483648 / 64'd56),
        31'(64'd2147483648 / 64'd30), 31'(64'd2147483648 / 64'd12),
        31'(64'd2147483648 / 64'd2)};
    localparam logic [30:0] SIN_RCP [5] = '{
        31'(64'd2147483648 / 64'd110), 31'(64'd2147483648 / 64'd72),
        31'(64'd2147483648 / 64'd42), 31'(64'd2147483648 / 64'd20),
        31'(64'd2147483648 / 64'd6)};

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_K, ST_LD_KW, ST_LD_V, ST_LD_VW, ST_LD_T, ST_LD_TW, ST_LD_SC, ST_LD_SCW,
        ST_EV_P, ST_EV_P2, ST_EV_RD, ST_EV_KV, ST_EV_KT0, ST_EV_KT1, ST_EV_KT2,
        ST_EV_DP, ST_EV_KX0, ST_EV_KX1, ST_EV_PH, ST_EV_CGO, ST_EV_CW,
        ST_EV_AMP, ST_EV_MAG, ST_EV_MLO, ST_EV_MHI, ST_EV_ACC, ST_EV_DONE
    } tidtec_state_t;

    typedef enum logic [2:0] {
        SC_IDLE, SC_X, SC_Z, SC_MUL, SC_RCP, SC_FIX, SC_SIN, SC_OUT
    } sc_state_t;

endpackage

[design/tidtec_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module tidtec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/tidtec_div.sv]
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module tidtec_div import tidtec_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        done
);

    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic        fits;

    assign rem_sh = {rem_reg, quo_reg[63]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= 32'(rem_sh - {1'b0, dvs_reg});
            end else begin
                rem_reg <= rem_sh[31:0];
            end
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[design/tidtec_sincos.sv]
// Iterative sine and cosine of an angle in turns, nested Taylor steps on one multiplier.
module tidtec_sincos import tidtec_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out,
    output logic               done
);

    sc_state_t state_reg, state_next;

    logic [67:0] prod_reg;
    logic [33:0] mul_a, mul_b;
    logic [1:0]  quad_reg;
    logic        fold_reg;
    logic [29:0] x_reg;
    logic [29:0] z_reg;
    logic [29:0] y_reg;
    logic [30:0] t_reg;
    logic [30:0] cc_reg;
    logic [2:0]  step_reg;
    logic        chain_reg;
    logic        done_reg;
    logic signed [31:0] cos_reg, sin_reg;

    logic [30:0] r_fold;
    logic [6:0]  cur_div;
    logic [30:0] cur_rcp;
    logic [29:0] q0;
    logic [36:0] q0d;
    logic [31:0] rdiff;
    logic [30:0] t_new;
    logic signed [31:0] cc_s, ss_s, c_f, s_f;

    assign r_fold  = angle[29] ? 31'(31'd1073741824 - {1'b0, angle[29:0]})
                               : {1'b0, angle[29:0]};
    assign cur_div = chain_reg ? SIN_DIV[step_reg] : COS_DIV[step_reg];
    assign cur_rcp = chain_reg ? SIN_RCP[step_reg] : COS_RCP[step_reg];
    assign q0      = prod_reg[60:31];
    assign q0d     = 37'(q0) * 37'(cur_div);
    assign rdiff   = 32'({2'b00, y_reg} - q0d[31:0]);
    assign t_new   = 31'(Q30_ONE - 31'((rdiff >= 32'(cur_div)) ? q0 + 30'd1 : q0));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SC_IDLE: if (start) state_next = SC_X;
            SC_X:    state_next = SC_Z;
            SC_Z:    state_next = SC_MUL;
            SC_MUL:  state_next = SC_RCP;
            SC_RCP:  state_next = SC_FIX;
            SC_FIX: begin
                if (step_reg == 3'd4 && chain_reg) begin
                    state_next = SC_SIN;
                end else begin
                    state_next = SC_MUL;
                end
            end
            SC_SIN:  state_next = SC_OUT;
            SC_OUT:  state_next = SC_IDLE;
            default: state_next = SC_IDLE;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            SC_IDLE: begin
                mul_a = {3'b000, r_fold};
                mul_b = PI_Q32;
            end
            SC_X: begin
                mul_a = {4'b0000, prod_reg[62:33]};
                mul_b = {4'b0000, prod_reg[62:33]};
            end
            SC_MUL: begin
                mul_a = {4'b0000, z_reg};
                mul_b = {3'b000, t_reg};
            end
            SC_RCP: begin
                mul_a = {4'b0000, prod_reg[59:30]};
                mul_b = {3'b000, cur_rcp};
            end
            SC_SIN: begin
                mul_a = {4'b0000, x_reg};
                mul_b = {3'b000, t_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SC_OUT);
        end
    end

    assign cc_s = {1'b0, cc_reg};
    assign ss_s = {1'b0, prod_reg[60:30]};

    always_comb begin
        logic signed [31:0] a, b;
        a = fold_reg ? ss_s : cc_s;
        b = fold_reg ? cc_s : ss_s;
        case (quad_reg)
            2'd0: begin c_f = a;  s_f = b;  end
            2'd1: begin c_f = -b; s_f = a;  end
            2'd2: begin c_f = -a; s_f = -b; end
            default: begin c_f = b; s_f = -a; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            SC_IDLE: begin
                quad_reg <= angle[31:30];
                fold_reg <= angle[29];
            end
            SC_X: x_reg <= prod_reg[62:33];
            SC_Z: begin
                z_reg     <= prod_reg[59:30];
                t_reg     <= Q30_ONE;
                step_reg  <= '0;
                chain_reg <= 1'b0;
            end
            SC_RCP: y_reg <= prod_reg[59:30];
            SC_FIX: begin
                if (step_reg == 3'd4) begin
                    if (!chain_reg) begin
                        cc_reg    <= t_new;
                        t_reg     <= Q30_ONE;
                        chain_reg <= 1'b1;
                        step_reg  <= '0;
                    end else begin
                        t_reg <= t_new;
                    end
                end else begin
                    t_reg    <= t_new;
                    step_reg <= step_reg + 3'd1;
                end
            end
            SC_OUT: begin
                cos_reg <= c_f;
                sin_reg <= s_f;
            end
            default: ;
        endcase
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
    assign done    = done_reg;

endmodule

[design/tid_screen_tec_evaluator.sv]
// Top level of the ionospheric disturbance screen evaluator.
// A load beat derives and stores one wave component: two divisions on the serial divider,
// a reciprocal multiplication for the angle and one pass of the sine and cosine unit. An
// evaluate beat works through the n active components in turn on the shared cosine unit,
// which runs two cosines per component. The component table sits in one 160-bit wide
// memory that is read once per component. A finished result waits in the output register
// while the next beat is taken.
module tid_screen_tec_evaluator import tidtec_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // comp_index, comp_amp, comp_wavelength, comp_theta, comp_speed, lon, lat,
    // path_factor, then zero fill
    input  logic [IN_W-1:0]   s_tdata,
    // action
    input  logic              s_tuser,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    // tec_value
    output logic [OUT_W-1:0]  m_tdata,
    // saturated
    output logic              m_tuser,
    output logic              m_tlast,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    tidtec_state_t state_reg, state_next;

    logic [31:0] tec0_reg;
    logic [10:0] height_reg;
    logic [39:0] time_reg;
    logic [4:0]  count_reg;

    logic [IN_W-1:0] item_reg;
    logic            last_reg;
    logic [13:0]     rh_reg;

    logic [31:0]       amp_f, wl_f, theta_f, speed_f, lon_f, lat_f, path_f;

    logic signed [67:0] prod_reg;
    logic signed [33:0] mul_a, mul_b;

    logic        div_start, div_done;
    logic [63:0] div_dvd, div_q;
    logic [31:0] div_dvs;

    logic              sc_start, sc_done;
    logic signed [31:0] sc_c, sc_s;

    logic               ram_rd_en, ram_wr_en;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic [31:0]        e_amp, e_k, e_cos, e_sin, e_v;

    logic [31:0] k_reg, v_reg, u_reg;
    logic [43:0] p_reg;
    logic [CNT_W-1:0] comp_reg, n_reg;
    logic        side_reg;
    logic [63:0] kv_reg, kt_reg, ph_reg;
    logic [31:0] xh_reg;
    logic signed [31:0] c1_reg;
    logic signed [32:0] s_reg;
    logic [32:0] m_reg;
    logic        neg_reg;
    logic [32:0] mlo_reg;
    logic signed [63:0] acc_reg;

    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;
    logic               m_tuser_reg, m_tlast_reg;

    logic [31:0] theta_mag;
    logic [31:0] theta_qa;
    logic [31:0] theta_ra;
    logic [12:0] theta_v;
    logic [26:0] theta_vq;
    logic [6:0]  theta_q2;
    logic [12:0] theta_r2;
    logic [63:0] theta_quo;
    logic [63:0] theta_q;
    logic [63:0] ph_new;
    logic [67:0] abs_a;
    logic [53:0] mag;
    logic signed [63:0] acc_new;
    logic        out_free;

    assign amp_f   = item_reg[35:4];
    assign wl_f    = item_reg[67:36];
    assign theta_f = item_reg[99:68];
    assign speed_f = item_reg[131:100];
    assign lon_f   = item_reg[163:132];
    assign lat_f   = item_reg[195:164];
    assign path_f  = item_reg[227:196];

    assign e_amp = ram_rd_data[31:0];
    assign e_k   = ram_rd_data[63:32];
    assign e_cos = ram_rd_data[95:64];
    assign e_sin = ram_rd_data[127:96];
    assign e_v   = ram_rd_data[159:128];

    assign out_free = !m_tvalid_reg || m_tready;

    // The angle in turns is floor(theta*128/45): the magnitude of theta is split by 45,
    // then the remainder times 128 is split again.
    assign theta_mag = theta_f[31] ? 32'(-theta_f) : theta_f;
    assign theta_qa  = 32'(prod_reg[67:38]);
    assign theta_ra  = theta_mag - 32'(theta_qa * 32'(THETA_DIV));
    assign theta_v   = {theta_ra[5:0], 7'b0000000};
    assign theta_vq  = 27'(theta_v) * 27'(THETA_FRAC_RCP);
    assign theta_q2  = theta_vq[25:19];
    assign theta_r2  = 13'(theta_v - 13'(13'(theta_q2) * 13'(THETA_DIV)));
    assign theta_quo = 64'({theta_qa, 7'b0000000}) + 64'(theta_q2);
    assign theta_q   = theta_f[31] ? 64'(-(theta_quo + 64'(theta_r2 != 13'd0))) : theta_quo;

    assign ph_new = ph_reg + {prod_reg[31:0], 32'h0} - kt_reg;
    assign abs_a  = prod_reg[67] ? 68'(-prod_reg) : 68'(prod_reg);
    assign mag    = 54'(prod_reg[52:0]) + 54'(mlo_reg);
    assign acc_new = acc_reg + (neg_reg ? -64'(mag) : 64'(mag)) + 64'({tec0_reg, 8'h00});

    tidtec_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COMPONENTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (item_reg[CIDX_W-1:0]),
        .wr_data ({v_reg, sc_s, sc_c, k_reg, amp_f}),
        .rd_en   (ram_rd_en),
        .rd_addr (comp_reg[CIDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    tidtec_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .quotient  (div_q),
        .done      (div_done)
    );

    tidtec_sincos u_sincos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start),
        .angle   (u_reg),
        .cos_out (sc_c),
        .sin_out (sc_s),
        .done    (sc_done)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == ACT_LOAD) ? ST_LD_K : ST_EV_P;
                end
            end
            ST_LD_K:   state_next = ST_LD_KW;
            ST_LD_KW:  if (div_done) state_next = ST_LD_V;
            ST_LD_V:   state_next = ST_LD_VW;
            ST_LD_VW:  if (div_done) state_next = ST_LD_T;
            ST_LD_T:   state_next = ST_LD_TW;
            ST_LD_TW:  state_next = ST_LD_SC;
            ST_LD_SC:  state_next = ST_LD_SCW;
            ST_LD_SCW: if (sc_done) state_next = ST_IDLE;
            ST_EV_P:   state_next = ST_EV_P2;
            ST_EV_P2:  state_next = (n_reg == '0) ? ST_EV_DONE : ST_EV_RD;
            ST_EV_RD:  state_next = ST_EV_KV;
            ST_EV_KV:  state_next = ST_EV_KT0;
            ST_EV_KT0: state_next = ST_EV_KT1;
            ST_EV_KT1: state_next = ST_EV_KT2;
            ST_EV_KT2: state_next = ST_EV_DP;
            ST_EV_DP:  state_next = ST_EV_KX0;
            ST_EV_KX0: state_next = ST_EV_KX1;
            ST_EV_KX1: state_next = ST_EV_PH;
            ST_EV_PH:  state_next = ST_EV_CGO;
            ST_EV_CGO: state_next = ST_EV_CW;
            ST_EV_CW: begin
                if (sc_done) begin
                    state_next = side_reg ? ST_EV_AMP : ST_EV_DP;
                end
            end
            ST_EV_AMP: state_next = ST_EV_MAG;
            ST_EV_MAG: state_next = ST_EV_MLO;
            ST_EV_MLO: state_next = ST_EV_MHI;
            ST_EV_MHI: state_next = ST_EV_ACC;
            ST_EV_ACC: begin
                state_next = (CNT_W'(comp_reg + 1'b1) == n_reg) ? ST_EV_DONE : ST_EV_RD;
            end
            ST_EV_DONE: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        sc_start  = 1'b0;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_LD_K: begin
                div_start = 1'b1;
                div_dvd   = {18'h0, rh_reg, 32'h0};
                div_dvs   = wl_f;
            end
            ST_LD_V: begin
                div_start = 1'b1;
                div_dvd   = {8'h00, speed_f, 24'h0};
                div_dvs   = 32'(rh_reg) * 32'(SECONDS_PER_HOUR);
            end
            ST_LD_T: begin
                mul_a = {2'b00, theta_mag};
                mul_b = {1'b0, THETA_RCP};
            end
            ST_LD_SC: sc_start = 1'b1;
            ST_LD_SCW: ram_wr_en = sc_done;
            ST_EV_P: begin
                mul_a = {2'b00, path_f};
                mul_b = {2'b00, tec0_reg};
            end
            ST_EV_RD: ram_rd_en = 1'b1;
            ST_EV_KV: begin
                mul_a = {2'b00, e_k};
                mul_b = {2'b00, e_v};
            end
            ST_EV_KT0: begin
                mul_a = {2'b00, prod_reg[31:0]};
                mul_b = {2'b00, time_reg[31:0]};
            end
            ST_EV_KT1: begin
                mul_a = {2'b00, kv_reg[31:0]};
                mul_b = {26'h0, time_reg[39:32]};
            end
            ST_EV_KT2: begin
                mul_a = {2'b00, kv_reg[63:32]};
                mul_b = {2'b00, time_reg[31:0]};
            end
            ST_EV_DP: begin
                mul_a = side_reg ? {{2{e_sin[31]}}, e_sin} : {{2{e_cos[31]}}, e_cos};
                mul_b = side_reg ? {{2{lat_f[31]}}, lat_f} : {{2{lon_f[31]}}, lon_f};
            end
            ST_EV_KX0: begin
                mul_a = {2'b00, e_k};
                mul_b = {2'b00, prod_reg[41:10]};
            end
            ST_EV_KX1: begin
                mul_a = {2'b00, e_k};
                mul_b = {{2{xh_reg[31]}}, xh_reg};
            end
            ST_EV_CGO: sc_start = 1'b1;
            ST_EV_AMP: begin
                mul_a = {{2{e_amp[31]}}, e_amp};
                mul_b = {s_reg[32], s_reg};
            end
            ST_EV_MLO: begin
                mul_a = {10'h0, p_reg[23:0]};
                mul_b = {1'b0, m_reg};
            end
            ST_EV_MHI: begin
                mul_a = {14'h0, p_reg[43:24]};
                mul_b = {1'b0, m_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            tec0_reg     <= 32'd65536;
            height_reg   <= 11'd300;
            time_reg     <= '0;
            count_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == ST_EV_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TEC0:   tec0_reg   <= cfg_wdata[31:0];
                    CFG_HEIGHT: height_reg <= cfg_wdata[10:0];
                    CFG_TIME:   time_reg   <= cfg_wdata[39:0];
                    CFG_COUNT:  count_reg  <= cfg_wdata[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    item_reg <= s_tdata;
                    last_reg <= s_tlast;
                    rh_reg   <= 14'(EARTH_RADIUS_KM) + 14'(height_reg);
                    n_reg    <= (count_reg > 5'(MAX_COMPONENTS))
                                ? CNT_W'(MAX_COMPONENTS) : CNT_W'(count_reg);
                end
            end
            ST_LD_KW: k_reg <= (div_q[63:32] != 32'h0) ? 32'hFFFF_FFFF : div_q[31:0];
            ST_LD_VW: v_reg <= div_q[31:0];
            ST_LD_TW: u_reg <= theta_q[31:0];
            ST_EV_P2: begin
                p_reg    <= prod_reg[63:20];
                comp_reg <= '0;
                side_reg <= 1'b0;
                acc_reg  <= '0;
            end
            ST_EV_KT0: kv_reg <= prod_reg[63:0];
            ST_EV_KT1: kt_reg <= prod_reg[63:0];
            ST_EV_KT2: kt_reg <= kt_reg + {prod_reg[31:0], 32'h0};
            ST_EV_DP: begin
                if (!side_reg) begin
                    kt_reg <= kt_reg + {prod_reg[31:0], 32'h0};
                end
            end
            ST_EV_KX0: xh_reg <= {{10{prod_reg[63]}}, prod_reg[63:42]};
            ST_EV_KX1: ph_reg <= prod_reg[63:0];
            ST_EV_PH:  u_reg  <= 32'(ph_new[63:64-PHASE_BITS]) << (32 - PHASE_BITS);
            ST_EV_CW: begin
                if (sc_done) begin
                    if (!side_reg) begin
                        c1_reg   <= sc_c;
                        side_reg <= 1'b1;
                    end else begin
                        s_reg    <= 33'(c1_reg) + 33'(sc_c);
                        side_reg <= 1'b0;
                    end
                end
            end
            ST_EV_MAG: begin
                m_reg   <= abs_a[62:30];
                neg_reg <= prod_reg[67];
            end
            ST_EV_MHI: mlo_reg <= prod_reg[56:24];
            ST_EV_ACC: begin
                acc_reg  <= acc_new;
                comp_reg <= CNT_W'(comp_reg + 1'b1);
            end
            ST_EV_DONE: begin
                if (out_free) begin
                    m_tlast_reg <= last_reg;
                    if (acc_reg > OUT_MAX) begin
                        m_tdata_reg <= OUT_MAX[47:0];
                        m_tuser_reg <= 1'b1;
                    end else if (acc_reg < OUT_MIN) begin
                        m_tdata_reg <= OUT_MIN[47:0];
                        m_tuser_reg <= 1'b1;
                    end else begin
                        m_tdata_reg <= acc_reg[47:0];
                        m_tuser_reg <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EV_DONE))
        else $error("Result raised outside the result state.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_LD_KW || state_reg == ST_LD_VW))
        else $error("Divider finished while no division was awaited.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        sc_done |-> (state_reg == ST_LD_SCW || state_reg == ST_EV_CW))
        else $error("Cosine unit finished while no result was awaited.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EV_RD) |-> (comp_reg < n_reg))
        else $error("Component read beyond the active count.");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the disturbance screen evaluator: random component loads and evaluations.
`timescale 1ns / 1ps

module tb;
    import tidtec_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic        action;
        logic [3:0]  idx;
        logic [31:0] amp;
        logic [31:0] wavelen;
        logic [31:0] theta;
        logic [31:0] speed;
        logic [31:0] lon;
        logic [31:0] lat;
        logic [31:0] path;
        logic        last;
    } screen_beat_t;

    typedef struct packed {
        logic [47:0] tec;
        logic        sat;
        logic        last;
    } tec_result_t;

    localparam longint CYCLE_LIMIT = 10_000_000;
    localparam int     SETTLE_CYCLES = 400;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              s_tuser;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;

    tid_screen_tec_evaluator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Shadow copy of the screen's registers and component table.
    logic [31:0] tec0_reg;
    logic [10:0] height_reg;
    logic [39:0] time_reg;
    logic [4:0]  count_reg;
    logic [31:0] amp_mem [MAX_COMPONENTS];
    logic [31:0] knum_mem [MAX_COMPONENTS];
    logic [31:0] dcos_mem [MAX_COMPONENTS];
    logic [31:0] dsin_mem [MAX_COMPONENTS];
    logic [31:0] omega_mem [MAX_COMPONENTS];

    screen_beat_t pending_beats [$];
    tec_result_t  tec_expected [$];
    screen_beat_t beat_on_bus;
    int           errors = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    bit           calm = 0;
    longint       cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic u64_t nest_poly(u64_t z, bit sine);
        u64_t t;
        u64_t d;
        t = u64_t'(Q30_ONE);
        for (int i = 0; i < 5; i++) begin
            d = sine ? u64_t'(SIN_DIV[i]) : u64_t'(COS_DIV[i]);
            t = u64_t'(Q30_ONE) - ((z * t) >> 30) / d;
        end
        return t;
    endfunction

    function automatic void turn_sincos(logic [31:0] u, output longint c, output longint s);
        u64_t   w, r, x, z;
        longint cc, ss, tmp;
        w = u64_t'(u[29:0]);
        r = u[29] ? (64'h4000_0000 - w) : w;
        x = (r * u64_t'(PI_Q32)) >> 33;
        z = (x * x) >> 30;
        cc = longint'(nest_poly(z, 1'b0));
        ss = longint'((x * nest_poly(z, 1'b1)) >> 30);
        if (u[29]) begin
            tmp = cc; cc = ss; ss = tmp;
        end
        case (u[31:30])
            2'd0: begin c = cc;  s = ss;  end
            2'd1: begin c = -ss; s = cc;  end
            2'd2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    function automatic longint wave_cos(u64_t k, logic [31:0] dir, logic [31:0] pos, u64_t kt);
        longint prod;
        u64_t   ph;
        longint c, s;
        prod = longint'($signed(dir)) * longint'($signed(pos));
        ph = k * u64_t'(prod >>> 10) - kt;
        turn_sincos(32'(ph >> (64 - PHASE_BITS)) << (32 - PHASE_BITS), c, s);
        return c;
    endfunction

    function automatic void derive_component(screen_beat_t b);
        u64_t   rh, k;
        longint n, q, c, s;
        rh = u64_t'(EARTH_RADIUS_KM) + u64_t'(height_reg);
        k = (b.wavelen == 0) ? 64'hFFFF_FFFF : (rh << 32) / u64_t'(b.wavelen);
        if (k > 64'hFFFF_FFFF) k = 64'hFFFF_FFFF;
        n = longint'($signed(b.theta)) * 128;
        q = n / 45;
        if ((n % 45) != 0 && n < 0) q--;
        turn_sincos(q[31:0], c, s);
        amp_mem[b.idx]   = b.amp;
        knum_mem[b.idx]  = k[31:0];
        dcos_mem[b.idx]  = c[31:0];
        dsin_mem[b.idx]  = s[31:0];
        omega_mem[b.idx] = 32'((u64_t'(b.speed) << 24) / (rh * u64_t'(SECONDS_PER_HOUR)));
    endfunction

    function automatic tec_result_t tec_for_direction(screen_beat_t b);
        tec_result_t r;
        u64_t   p, p_hi, p_lo, k, kt, m, mag;
        longint cs, a, acc;
        int     n;
        acc = 0;
        r.sat = 1'b0;
        p = (u64_t'(b.path) * u64_t'(tec0_reg)) >> 20;
        p_hi = p >> 24;
        p_lo = p & 64'hFF_FFFF;
        n = (count_reg > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(count_reg);
        for (int i = 0; i < n; i++) begin
            k = u64_t'(knum_mem[i]);
            kt = k * u64_t'(omega_mem[i]) * u64_t'(time_reg);
            cs = wave_cos(k, dcos_mem[i], b.lon, kt) + wave_cos(k, dsin_mem[i], b.lat, kt);
            a = longint'($signed(amp_mem[i])) * cs;
            m = (a < 0) ? (u64_t'(-a) >> 30) : (u64_t'(a) >> 30);
            mag = p_hi * m + ((p_lo * m) >> 24);
            acc += ((a < 0) ? -longint'(mag) : longint'(mag)) + longint'(tec0_reg) * 256;
        end
        if (acc > OUT_MAX) begin
            acc = OUT_MAX; r.sat = 1'b1;
        end
        if (acc < OUT_MIN) begin
            acc = OUT_MIN; r.sat = 1'b1;
        end
        r.tec = acc[47:0];
        r.last = b.last;
        return r;
    endfunction

    // Source side: one beat at a time from the pending queue, with random idle bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (beat_on_bus.action == ACT_EVAL) begin
                    tec_expected.push_back(tec_for_direction(beat_on_bus));
                end else begin
                    derive_component(beat_on_bus);
                end
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    beat_on_bus = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= beat_on_bus.action;
                    s_tlast  <= beat_on_bus.last;
                    s_tdata  <= {4'h0, beat_on_bus.path, beat_on_bus.lat, beat_on_bus.lon,
                                 beat_on_bus.speed, beat_on_bus.theta, beat_on_bus.wavelen,
                                 beat_on_bus.amp, beat_on_bus.idx};
                    if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: random back-pressure and comparison against the oldest expectation.
    always @(posedge aclk) begin
        tec_result_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[tid_screen_tec_evaluator] ERROR");
            $finish;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (tec_expected.size() == 0) begin
                    $error("unexpected result beat: tec_value %h", m_tdata);
                    errors++;
                end else begin
                    e = tec_expected.pop_front();
                    if (m_tdata !== e.tec) begin
                        $error("tec_value: expected %h, got %h", e.tec, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== e.sat) begin
                        $error("saturated: expected %b, got %b", e.sat, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_out: expected %b, got %b", e.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 16);
            end
        end
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic screen_beat_t random_beat(bit eval);
        screen_beat_t b;
        b.action  = eval ? ACT_EVAL : ACT_LOAD;
        b.idx     = 4'($urandom_range(0, 15));
        b.amp     = pick32();
        b.wavelen = pick32();
        b.theta   = pick32();
        b.speed   = pick32();
        b.lon     = pick32();
        b.lat     = pick32();
        b.path    = pick32();
        b.last    = 1'($urandom_range(0, 1));
        return b;
    endfunction

    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_tvalid || tec_expected.size() > 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_TEC0:   tec0_reg = val[31:0];
            CFG_HEIGHT: height_reg = val[10:0];
            CFG_TIME:   time_reg = val[39:0];
            default:    count_reg = val[4:0];
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        screen_beat_t b;
        int           n_items;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        tec0_reg = 32'd65536;
        height_reg = 11'd300;
        time_reg = '0;
        count_reg = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Evaluation with no active components, then a fill of every slot with extreme values.
        b = random_beat(1'b1);
        pending_beats.push_back(b);
        for (int i = 0; i < MAX_COMPONENTS; i++) begin
            b = random_beat(1'b0);
            b.idx = 4'(i);
            b.amp = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            b.wavelen = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : 32'h0001_0000 << (i % 8);
            b.theta = (i == 2) ? 32'h8000_0000 : (i == 3) ? 32'h7FFF_FFFF : $urandom;
            b.speed = (i == 4) ? 32'hFFFF_FFFF : (i == 5) ? 32'h0 : $urandom;
            pending_beats.push_back(b);
        end
        wait_drained();
        write_reg(CFG_COUNT, 40'd16);
        write_reg(CFG_TEC0, 40'hFFFF_FFFF);
        write_reg(CFG_TIME, 40'hFF_FFFF_FFFF);
        b = random_beat(1'b1);
        b.path = 32'hFFFF_FFFF; b.lon = 32'h7FFF_FFFF; b.lat = 32'h8000_0000; b.last = 1'b1;
        pending_beats.push_back(b);
        b.lon = 32'h8000_0000; b.lat = 32'h7FFF_FFFF; b.last = 1'b0;
        pending_beats.push_back(b);
        b.path = 32'h0;
        pending_beats.push_back(b);
        wait_drained();
        write_reg(CFG_COUNT, 40'd31);
        write_reg(CFG_HEIGHT, 40'd2047);
        write_reg(CFG_TEC0, 40'd0);
        pending_beats.push_back(random_beat(1'b1));
        b = random_beat(1'b0);
        b.idx = 4'd15;
        pending_beats.push_back(b);
        pending_beats.push_back(random_beat(1'b1));

        // Random phases, each under a fresh register setting; the last one runs without idling.
        for (int ph = 0; ph < 44; ph++) begin
            wait_drained();
            if (ph == 43) calm = 1;
            write_reg(CFG_TEC0, ($urandom_range(0, 3) == 0) ? 40'(pick32()) : 40'($urandom_range(0, 1 << 20)));
            write_reg(CFG_HEIGHT, 40'($urandom_range(0, 2047)));
            write_reg(CFG_TIME, {$urandom_range(0, 255), $urandom});
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_COUNT, 40'($urandom_range(16, 31)));
                n_items = 15;
            end else begin
                write_reg(CFG_COUNT, 40'($urandom_range(0, 4)));
                n_items = 42;
            end
            for (int i = 0; i < n_items; i++)
                pending_beats.push_back(random_beat($urandom_range(0, 9) < 6));
        end
        wait_drained();

        if (errors == 0) begin
            $display("[tid_screen_tec_evaluator] OK");
        end else begin
            $display("[tid_screen_tec_evaluator] ERROR");
        end
        $finish;
    end

endmodule
